### sv/rhsv_pkg.sv
// rhsv_pkg: shared types and constants for the rgb to hsv pixel pipeline
// used by rhsv_front, rhsv_div_stage and rgb_to_hsv_pixel_top
package rhsv_pkg;

  localparam int unsigned PixW   = 8;
  localparam int unsigned DivStg = 8;   // one quotient bit per stage

  // hue numerator 255*num with num <= 1530, divisor 6*d <= 1530
  localparam int unsigned HRemW = 19;
  localparam int unsigned HDivW = 18;   // 11-bit divisor pre-shifted by 7
  // saturation numerator 255*d, divisor max
  localparam int unsigned SRemW = 16;
  localparam int unsigned SDivW = 15;   // 8-bit divisor pre-shifted by 7

  typedef struct packed {
    logic [HRemW-1:0] hrem;
    logic [HDivW-1:0] hdiv;
    logic [PixW-1:0]  hq;
    logic [SRemW-1:0] srem;
    logic [SDivW-1:0] sdiv;
    logic [PixW-1:0]  sq;
    logic [PixW-1:0]  val;
  } div_t;

endpackage

### sv/rhsv_front.sv
// rhsv_front: two register stages that find max, min and the hue sector,
// then form the numerators and divisors for the dividers; uses rhsv_pkg
module rhsv_front import rhsv_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [PixW-1:0] red,
  input  logic [PixW-1:0] green,
  input  logic [PixW-1:0] blue,
  output logic            out_valid,
  input  logic            out_ready,
  output div_t            out_data
);

  // stage a registers
  logic            a_valid;
  logic [PixW-1:0] a_max;
  logic [PixW-1:0] a_diff;
  logic [10:0]     a_num;
  logic            a_grey;
  logic            a_ready;
  logic            in_ready_b;

  logic [PixW-1:0] mx, mn, d;
  logic [10:0]     num;

  always_comb begin
    mx = red;
    if (green > mx) mx = green;
    if (blue > mx) mx = blue;
    mn = red;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    d = mx - mn;
    // sixths times d; modulo 2^11 wraps back to a non-negative value
    if (blue == mx) begin
      num = {1'b0, d, 2'b00} + {3'b000, red} - {3'b000, green};
    end else if (green == mx) begin
      num = {2'b00, d, 1'b0} + {3'b000, blue} - {3'b000, red};
    end else if (green > blue) begin
      num = {3'b000, green} - {3'b000, blue};
    end else begin
      num = {1'b0, d, 2'b00} + {2'b00, d, 1'b0} + {3'b000, green} - {3'b000, blue};
    end
  end

  assign a_ready  = !a_valid || in_ready_b;
  assign in_ready = a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= in_valid;
    end
    if (a_ready && in_valid) begin
      a_max  <= mx;
      a_diff <= d;
      a_num  <= num;
      a_grey <= (mx == mn);
    end
  end

  // stage b: numerators scaled by 255, divisors aligned to the top quotient bit
  logic [10:0] six_d;
  div_t        b_next;

  always_comb begin
    six_d       = {1'b0, a_diff, 2'b00} + {2'b00, a_diff, 1'b0};
    b_next.hrem = {a_num, 8'h00} - {8'h00, a_num};
    b_next.srem = {a_diff, 8'h00} - {8'h00, a_diff};
    b_next.hq   = '0;
    b_next.sq   = '0;
    b_next.val  = a_max;
    // grey has zero numerators; a divisor of one keeps the quotients at zero
    if (a_grey) begin
      b_next.hdiv = {11'd1, 7'd0};
      b_next.sdiv = {8'd1, 7'd0};
    end else begin
      b_next.hdiv = {six_d, 7'd0};
      b_next.sdiv = {a_max, 7'd0};
    end
  end

  assign in_ready_b = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready_b) begin
      out_valid <= a_valid;
    end
    if (in_ready_b && a_valid) begin
      out_data <= b_next;
    end
  end

endmodule

### sv/rhsv_div_stage.sv
// rhsv_div_stage: one restoring division step for both hue and saturation
// uses div_t from rhsv_pkg
module rhsv_div_stage import rhsv_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  div_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output div_t out_data
);

  div_t stage_next;
  logic h_bit, s_bit;

  always_comb begin
    h_bit = in_data.hrem >= {1'b0, in_data.hdiv};
    s_bit = in_data.srem >= {1'b0, in_data.sdiv};
    stage_next      = in_data;
    stage_next.hrem = h_bit ? in_data.hrem - {1'b0, in_data.hdiv} : in_data.hrem;
    stage_next.srem = s_bit ? in_data.srem - {1'b0, in_data.sdiv} : in_data.srem;
    stage_next.hq   = {in_data.hq[PixW-2:0], h_bit};
    stage_next.sq   = {in_data.sq[PixW-2:0], s_bit};
    // divisor walks down one bit position per stage
    stage_next.hdiv = in_data.hdiv >> 1;
    stage_next.sdiv = in_data.sdiv >> 1;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_data <= stage_next;
    end
  end

endmodule

### sv/rgb_to_hsv_pixel_top.sv
// rgb_to_hsv_pixel_top: pixel rgb to hsv converter
// depends on rhsv_pkg, rhsv_front and rhsv_div_stage
//
// usage
//   pixel channel: pix_valid / pix_ready with red, green, blue
//   result channel: hsv_valid / hsv_ready with hue, saturation, value
//   an item moves on a channel at a clock edge where valid and ready are high
// pipeline: a pixel passes through 2 front stages (max/min and sector, then
//   scaling) and 8 divider stages before hsv_valid
// throughput: one item per cycle unless hsv_ready stalls; the divider retires
//   a hue and a saturation quotient bit per stage, so every stage takes a new item
// each stage holds its own valid bit and ready is passed back stage by stage,
//   so empty stages fill up while the receiver stalls; pix_ready falls only
//   once all ten stages hold an item and hsv_ready is low
// a stall loses and repeats nothing: a held stage keeps its item
// reset (rst, synchronous) empties the pipeline; there is no other state
module rgb_to_hsv_pixel_top import rhsv_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            pix_valid,
  output logic            pix_ready,
  input  logic [PixW-1:0] red,
  input  logic [PixW-1:0] green,
  input  logic [PixW-1:0] blue,
  output logic            hsv_valid,
  input  logic            hsv_ready,
  output logic [PixW-1:0] hue,
  output logic [PixW-1:0] saturation,
  output logic [PixW-1:0] value
);

  logic stg_valid [0:DivStg];
  logic stg_ready [0:DivStg];
  div_t stg_data  [0:DivStg];

  rhsv_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pix_valid),
    .in_ready  (pix_ready),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .out_valid (stg_valid[0]),
    .out_ready (stg_ready[0]),
    .out_data  (stg_data[0])
  );

  for (genvar k = 0; k < DivStg; k++) begin : g_div
    rhsv_div_stage u_div (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stg_valid[k]),
      .in_ready  (stg_ready[k]),
      .in_data   (stg_data[k]),
      .out_valid (stg_valid[k+1]),
      .out_ready (stg_ready[k+1]),
      .out_data  (stg_data[k+1])
    );
  end

  assign stg_ready[DivStg] = hsv_ready;
  assign hsv_valid         = stg_valid[DivStg];
  assign hue               = stg_data[DivStg].hq;
  assign saturation        = stg_data[DivStg].sq;
  assign value             = stg_data[DivStg].val;

  // zero saturation only comes from grey, which has zero hue
  a_grey_hue: assert property (@(posedge clk) disable iff (rst)
    hsv_valid && saturation == '0 |-> hue == '0)
    else $error("grey item with non-zero hue");

  // black gives zero saturation
  a_black_sat: assert property (@(posedge clk) disable iff (rst)
    hsv_valid && value == '0 |-> saturation == '0)
    else $error("black item with non-zero saturation");

  // input back-pressure only when the pipe is full and the receiver stalls
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !pix_ready |-> hsv_valid && !hsv_ready)
    else $error("pixel channel stalled while the pipeline can move");

endmodule

### tb/tb_rgb_to_hsv_pixel_top.sv
// tb_rgb_to_hsv_pixel_top: self-checking bench for the rgb to hsv pixel converter
// depends on rhsv_pkg and rgb_to_hsv_pixel_top; predicts each result with exact
// integer arithmetic and checks results in order under random idling and a long stall
`timescale 1ns / 1ps

module tb_rgb_to_hsv_pixel_top;
  import rhsv_pkg::*;

  typedef struct packed {
    logic [PixW-1:0] hue;
    logic [PixW-1:0] sat;
    logic [PixW-1:0] val;
  } hsv_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            pix_valid = 1'b0;
  logic            pix_ready;
  logic [PixW-1:0] red = '0;
  logic [PixW-1:0] green = '0;
  logic [PixW-1:0] blue = '0;
  logic            hsv_valid;
  logic            hsv_ready = 1'b0;
  logic [PixW-1:0] hue;
  logic [PixW-1:0] saturation;
  logic [PixW-1:0] value;

  hsv_t expected_hsv[$];
  hsv_t want;
  int   errors = 0;
  int   src_idle_pct = 0;
  int   sink_idle_pct = 0;
  int   hold_asks = 0;
  int   hold_seen = 0;
  int   hold_left = 0;

  rgb_to_hsv_pixel_top DUT (
    .clk(clk),
    .rst(rst),
    .pix_valid(pix_valid),
    .pix_ready(pix_ready),
    .red(red),
    .green(green),
    .blue(blue),
    .hsv_valid(hsv_valid),
    .hsv_ready(hsv_ready),
    .hue(hue),
    .saturation(saturation),
    .value(value)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("DONE: errors detected");
    $finish;
  end

  // exact hue/saturation/value of one pixel
  function automatic hsv_t hsv_of_pixel(input logic [PixW-1:0] r, g, b);
    int unsigned mx, mn, d, num, h;
    hsv_t res;
    mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    res.val = mx[PixW-1:0];
    if (mx == mn) begin
      res.hue = '0;
      res.sat = '0;
      return res;
    end
    d = mx - mn;
    res.sat = PixW'((255 * d) / mx);
    // numerator is sixths of a turn times d
    if (b == mx) begin
      num = 4 * d + r - g;
    end else if (g == mx) begin
      num = 2 * d + b - r;
    end else if (g > b) begin
      num = g - b;
    end else begin
      num = 6 * d + g - b;
    end
    h = (255 * num) / (6 * d);
    if (h > 255) h = 255;
    res.hue = h[PixW-1:0];
    return res;
  endfunction

  // result receiver: random idling, or a long hold-off when one is asked for
  always @(posedge clk) begin
    if (rst) begin
      hsv_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hsv_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (hold_seen != hold_asks) begin
      hold_seen = hold_asks;
      hold_left = 80;
      hsv_ready <= 1'b0;
    end else begin
      hsv_ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && hsv_valid && hsv_ready) begin
      if (expected_hsv.size() == 0) begin
        $error("unexpected item: hue %0d saturation %0d value %0d", hue, saturation, value);
        errors++;
      end else begin
        want = expected_hsv.pop_front();
        if (hue !== want.hue) begin
          $error("hue: expected %0d, got %0d", want.hue, hue);
          errors++;
        end
        if (saturation !== want.sat) begin
          $error("saturation: expected %0d, got %0d", want.sat, saturation);
          errors++;
        end
        if (value !== want.val) begin
          $error("value: expected %0d, got %0d", want.val, value);
          errors++;
        end
      end
    end
  end

  task automatic send_pixel(input logic [PixW-1:0] r, g, b);
    if ($urandom_range(99) < src_idle_pct) begin
      pix_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    pix_valid <= 1'b1;
    red <= r;
    green <= g;
    blue <= b;
    @(posedge clk);
    while (!pix_ready) @(posedge clk);
    expected_hsv.push_back(hsv_of_pixel(r, g, b));
  endtask

  task automatic wait_drained();
    int waited;
    waited = 0;
    pix_valid <= 1'b0;
    while (expected_hsv.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    if (expected_hsv.size() != 0) begin
      $error("%0d items never came out", expected_hsv.size());
      errors++;
    end
    repeat (12) @(posedge clk);
  endtask

  task automatic test_special_pixels();
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd1, 8'd1, 8'd1);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    // red max with green equal to blue wraps to a full turn
    send_pixel(8'd255, 8'd10, 8'd10);
    send_pixel(8'd2, 8'd1, 8'd1);
    send_pixel(8'd255, 8'd128, 8'd0);
    send_pixel(8'd255, 8'd0, 8'd128);
    send_pixel(8'd200, 8'd199, 8'd198);
    send_pixel(8'd200, 8'd198, 8'd199);
    // ties for the largest component
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd10, 8'd200, 8'd30);
    send_pixel(8'd30, 8'd10, 8'd200);
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd1);
    send_pixel(8'd0, 8'd1, 8'd0);
    send_pixel(8'd254, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd254, 8'd254);
    send_pixel(8'd170, 8'd85, 8'd0);
    wait_drained();
  endtask

  task automatic test_random_pixels(input int n);
    logic [PixW-1:0] r, g, b;
    int unsigned pick;
    repeat (n) begin
      r = PixW'($urandom_range(255));
      g = PixW'($urandom_range(255));
      b = PixW'($urandom_range(255));
      pick = $urandom_range(99);
      // bias towards greys, ties and near-greys where the sector logic is tight
      if (pick < 15) begin
        g = r;
        b = r;
      end else if (pick < 35) begin
        case ($urandom_range(2))
          0: g = r;
          1: b = r;
          default: b = g;
        endcase
      end else if (pick < 50) begin
        g = PixW'(r ^ $urandom_range(3));
        b = PixW'(r ^ $urandom_range(3));
      end
      send_pixel(r, g, b);
    end
    wait_drained();
  endtask

  task automatic test_output_stall();
    src_idle_pct = 0;
    sink_idle_pct = 0;
    hold_asks++;
    repeat (40) begin
      send_pixel(PixW'($urandom_range(255)), PixW'($urandom_range(255)),
                 PixW'($urandom_range(255)));
    end
    wait_drained();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    src_idle_pct = 21;
    sink_idle_pct = 67;
    test_special_pixels();
    test_random_pixels(300);

    src_idle_pct = 67;
    sink_idle_pct = 21;
    test_random_pixels(300);

    src_idle_pct = 0;
    sink_idle_pct = 0;
    test_random_pixels(300);

    test_output_stall();

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
